// ----- rtl/fgn_pkg.sv -----
// ----------------------------------------------------------------------------
// Fractal gradient noise package
// Shared types, constants and fixed-point helpers for the noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fgn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = 40;
  localparam int SUM_BITS    = 26;
  localparam int OUT_BITS    = 22;
  localparam int AMP_BITS    = FRAC_BITS + 1;

  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_LACUN   = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_TWO  = 2'd2;

  // Channel offsets, rounded to Q.16.
  localparam logic [31:0] OFF1_X = 32'd8649245;
  localparam logic [31:0] OFF1_Y = 32'd1388203;
  localparam logic [31:0] OFF1_Z = 32'd4654570;
  localparam logic [31:0] OFF2_X = 32'd15564276;
  localparam logic [31:0] OFF2_Y = 32'd729494;
  localparam logic [31:0] OFF2_Z = 32'd8724742;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [1:0]         channel;
  } fgn_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] noise_sum;
    logic                       saturated;
  } fgn_res_t;

  // State handed from one octave cell to the next.
  typedef struct packed {
    logic                       valid;
    logic signed [ACC_BITS-1:0] px;
    logic signed [ACC_BITS-1:0] py;
    logic signed [ACC_BITS-1:0] pz;
    logic [AMP_BITS-1:0]        amp;
    logic signed [SUM_BITS-1:0] sum;
  } fgn_link_t;

  // Q.16 product, rounded half up.
  function automatic logic signed [31:0] fxm(input logic signed [23:0] a,
                                             input logic signed [23:0] b);
    logic signed [47:0] pr;
    pr = a * b + 48'sd32768;
    return pr[47:16];
  endfunction

  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    v = (h < 4'd4) ? 19'(y) : ((h == 4'd12 || h == 4'd14) ? 19'(x) : 19'(z));
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fgn_front.sv -----
// ----------------------------------------------------------------------------
// Fractal noise front stage
// Adds the channel offset and seeds the link for the first octave cell.
// ----------------------------------------------------------------------------
`default_nettype none
module fgn_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire fgn_pkg::fgn_req_t req,
  output fgn_pkg::fgn_link_t    link
);
  import fgn_pkg::*;

  logic [31:0] ox, oy, oz;

  always_comb begin
    unique case (req.channel)
      CH_ONE: begin
        ox = OFF1_X; oy = OFF1_Y; oz = OFF1_Z;
      end
      CH_TWO: begin
        ox = OFF2_X; oy = OFF2_Y; oz = OFF2_Z;
      end
      default: begin
        ox = '0; oy = '0; oz = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    link.px  <= ACC_BITS'(req.pos_x) + $signed({8'd0, ox});
    link.py  <= ACC_BITS'(req.pos_y) + $signed({8'd0, oy});
    link.pz  <= ACC_BITS'(req.pos_z) + $signed({8'd0, oz});
    link.amp <= AMP_BITS'(1 << FRAC_BITS);
    link.sum <= '0;
    if (rst) begin
      link.valid <= 1'b0;
    end else begin
      link.valid <= start;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fgn_cell.sv -----
// ----------------------------------------------------------------------------
// Fractal noise octave cell
// Seven-stage pipeline: one octave of gradient noise added into the sum when
// active, then position and amplitude scaled for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module fgn_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              active,
  input  wire logic [15:0]       lacunarity,
  input  wire logic [15:0]       persistence,
  input  wire fgn_pkg::fgn_link_t link_in,
  output fgn_pkg::fgn_link_t     link_out
);
  import fgn_pkg::*;

  localparam int DEPTH = 6;

  // Sideband carried alongside the noise stages.
  fgn_link_t          side [DEPTH];
  logic [AMP_BITS-1:0] amp_cur [DEPTH];

  // Stage 1
  logic [15:0]        t1 [3];
  logic signed [17:0] t2 [3];
  logic signed [20:0] in1 [3];
  logic [7:0]         a1, b1, cz1;
  // Stage 2
  logic [15:0]        t2f [3];
  logic signed [17:0] t3 [3];
  logic signed [20:0] in2 [3];
  logic [7:0]         aa, ab, ba, bb;
  // Stage 3
  logic signed [17:0] fd [3];
  logic signed [18:0] g [8];
  // Stage 4..6
  logic signed [20:0] l4 [4];
  logic signed [17:0] v4, w4, w5;
  logic signed [20:0] m5 [2];
  logic signed [20:0] n6;

  logic signed [56:0] sx, sy, sz;
  logic [32:0]        amp_pr;
  logic signed [17:0] x0, y0, z0, x1, y1, z1;
  logic [7:0]         h [8];

  assign sx     = link_in.px * $signed({1'b0, lacunarity});
  assign sy     = link_in.py * $signed({1'b0, lacunarity});
  assign sz     = link_in.pz * $signed({1'b0, lacunarity});
  assign amp_pr = link_in.amp * persistence;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic [15:0] t;
      logic signed [23:0] ts;
      t = (k == 0) ? link_in.px[15:0] : (k == 1) ? link_in.py[15:0] : link_in.pz[15:0];
      ts = $signed({8'd0, t});
      t1[k]  <= t;
      t2[k]  <= 18'(fxm(ts, ts));
      in1[k] <= 21'(fxm(ts, 24'(6) * ts - 24'(15 << FRAC_BITS)) + 32'(10 << FRAC_BITS));
    end
    a1  <= PERM[link_in.px[23:16]] + link_in.py[23:16];
    b1  <= PERM[8'(link_in.px[23:16] + 8'd1)] + link_in.py[23:16];
    cz1 <= link_in.pz[23:16];

    side[0].px  <= sx[51:12];
    side[0].py  <= sy[51:12];
    side[0].pz  <= sz[51:12];
    side[0].amp <= amp_pr[32:16];
    side[0].sum <= link_in.sum;
    amp_cur[0]  <= link_in.amp;
    for (int s = 1; s < DEPTH; s++) begin
      side[s].px  <= side[s-1].px;
      side[s].py  <= side[s-1].py;
      side[s].pz  <= side[s-1].pz;
      side[s].amp <= side[s-1].amp;
      side[s].sum <= side[s-1].sum;
      amp_cur[s]  <= amp_cur[s-1];
    end

    // Stage 2
    for (int k = 0; k < 3; k++) begin
      t2f[k] <= t1[k];
      t3[k]  <= 18'(fxm(24'(t2[k]), $signed({8'd0, t1[k]})));
      in2[k] <= in1[k];
    end
    aa <= PERM[a1] + cz1;
    ab <= PERM[8'(a1 + 8'd1)] + cz1;
    ba <= PERM[b1] + cz1;
    bb <= PERM[8'(b1 + 8'd1)] + cz1;

    // Stage 3
    for (int k = 0; k < 3; k++) begin
      fd[k] <= 18'(fxm(24'(t3[k]), 24'(in2[k])));
    end
    for (int j = 0; j < 8; j++) begin
      g[j] <= grad(h[j][3:0], (j[0] ? x1 : x0), (j[1] ? y1 : y0), (j[2] ? z1 : z0));
    end

    // Stage 4: blend along x.
    for (int j = 0; j < 4; j++) begin
      l4[j] <= 21'(g[2*j]) + 21'(fxm(24'(fd[0]), 24'(g[2*j+1]) - 24'(g[2*j])));
    end
    v4 <= fd[1];
    w4 <= fd[2];

    // Stage 5: blend along y.
    for (int j = 0; j < 2; j++) begin
      m5[j] <= l4[2*j] + 21'(fxm(24'(v4), 24'(l4[2*j+1]) - 24'(l4[2*j])));
    end
    w5 <= w4;

    // Stage 6: blend along z.
    n6 <= m5[0] + 21'(fxm(24'(w5), 24'(m5[1]) - 24'(m5[0])));

    // Stage 7: weight and accumulate.
    link_out.px  <= side[DEPTH-1].px;
    link_out.py  <= side[DEPTH-1].py;
    link_out.pz  <= side[DEPTH-1].pz;
    link_out.amp <= side[DEPTH-1].amp;
    link_out.sum <= active
        ? side[DEPTH-1].sum + SUM_BITS'(fxm($signed({7'd0, amp_cur[DEPTH-1]}), 24'(n6)))
        : side[DEPTH-1].sum;

    if (rst) begin
      for (int s = 0; s < DEPTH; s++) side[s].valid <= 1'b0;
      link_out.valid <= 1'b0;
    end else begin
      side[0].valid <= link_in.valid;
      for (int s = 1; s < DEPTH; s++) side[s].valid <= side[s-1].valid;
      link_out.valid <= side[DEPTH-1].valid;
    end
  end

  // Gradient hashes in corner order: bit 0 picks x+1, bit 1 y+1, bit 2 z+1.
  always_comb begin
    x0 = $signed({2'd0, t2f[0]});
    y0 = $signed({2'd0, t2f[1]});
    z0 = $signed({2'd0, t2f[2]});
    x1 = x0 - 18'sd65536;
    y1 = y0 - 18'sd65536;
    z1 = z0 - 18'sd65536;
    h[0] = PERM[aa];
    h[1] = PERM[ba];
    h[2] = PERM[ab];
    h[3] = PERM[bb];
    h[4] = PERM[8'(aa + 8'd1)];
    h[5] = PERM[8'(ba + 8'd1)];
    h[6] = PERM[8'(ab + 8'd1)];
    h[7] = PERM[8'(bb + 8'd1)];
  end

endmodule
`default_nettype wire

// ----- rtl/fractal_gradient_noise_3d.sv -----
// ----------------------------------------------------------------------------
// Fractal 3-D gradient noise
// Octave sum of improved gradient noise over a chain of octave cells.
//
//   channel   direction  signals
//   request   in         start, busy, req
//   result    out        done, result
//   config    in         cfg_we, cfg_idx, cfg_data
//
// One request is taken every cycle; busy is always low. Each result passes
// through the front stage, the eight seven-stage octave cells in series and
// the output register. Reset is synchronous, clears the valid flags and
// loads the register defaults. The receiver cannot stall, so results are
// strobed by done.
// ----------------------------------------------------------------------------
`default_nettype none
module fractal_gradient_noise_3d (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire fgn_pkg::fgn_req_t req,
  output logic                  done,
  output fgn_pkg::fgn_res_t     result,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [15:0]      cfg_data
);
  import fgn_pkg::*;

  logic [3:0]  octave_count;
  logic [15:0] lacunarity;
  logic [15:0] persistence;
  fgn_link_t   links [MAX_OCTAVES+1];
  logic signed [SUM_BITS-1:0] s;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd4;
      lacunarity   <= 16'd8192;
      persistence  <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OCTAVES: octave_count <= cfg_data[3:0];
        REG_LACUN:   lacunarity   <= cfg_data;
        REG_PERSIST: persistence  <= cfg_data;
        default: ;
      endcase
    end
  end

  fgn_front u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .link (links[0])
  );

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fgn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .active     (octave_count > 4'(i)),
      .lacunarity (lacunarity),
      .persistence(persistence),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  assign s = links[MAX_OCTAVES].sum;

  always_ff @(posedge clk) begin
    if (s > SUM_BITS'((1 << (OUT_BITS-1)) - 1)) begin
      result.noise_sum <= OUT_BITS'((1 << (OUT_BITS-1)) - 1);
      result.saturated <= 1'b1;
    end else if (s < -SUM_BITS'(1 << (OUT_BITS-1))) begin
      result.noise_sum <= OUT_BITS'(1 << (OUT_BITS-1));
      result.saturated <= 1'b1;
    end else begin
      result.noise_sum <= s[OUT_BITS-1:0];
      result.saturated <= 1'b0;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= links[MAX_OCTAVES].valid;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for fractal_gradient_noise_3d
// Drives noise requests and configuration writes, predicts each fractal noise
// sum with an independent fixed-point model and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
  import fgn_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 70;

  // Channel offset vectors in units of 1/10000.
  localparam longint CH_OFFS [3][3] = '{
    '{0, 0, 0},
    '{1319770, 211823, 710231},
    '{2374920, 111312, 1331290}
  };

  class noise_scoreboard;
    fgn_res_t pending[$];
    int errors;
    int checked;
    int octaves;
    int lacun;
    int persist;

    function new();
      errors = 0;
      checked = 0;
      octaves = 4;
      lacun = 8192;
      persist = 32768;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_OCTAVES) octaves = int'(data[3:0]);
      else if (idx == REG_LACUN) lacun = int'(data);
      else if (idx == REG_PERSIST) persist = int'(data);
    endfunction

    function longint wrap40(longint v);
      logic signed [39:0] t;
      t = v[39:0];
      return longint'(t);
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + 32768) >>> 16;
    endfunction

    function longint fade(longint t);
      longint t2, t3, poly;
      t2 = qmul(t, t);
      t3 = qmul(t2, t);
      poly = qmul(t, 6 * t - 15 * 65536) + 10 * 65536;
      return qmul(t3, poly);
    endfunction

    function longint blend(longint t, longint a, longint b);
      return a + qmul(t, b - a);
    endfunction

    function int hashed(int i);
      return int'(PERM[8'(i)]);
    endfunction

    function longint slope(int hv, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hv[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
    endfunction

    function longint lattice_noise(longint px, longint py, longint pz);
      int cx, cy, cz, a, b, aa, ab, ba, bb;
      longint fx, fy, fz, u, v, w, x1, y1, z1, near_z, far_z;
      cx = int'(px[23:16]);
      cy = int'(py[23:16]);
      cz = int'(pz[23:16]);
      fx = longint'(px[15:0]);
      fy = longint'(py[15:0]);
      fz = longint'(pz[15:0]);
      u = fade(fx);
      v = fade(fy);
      w = fade(fz);
      a = hashed(cx) + cy;
      b = hashed(cx + 1) + cy;
      aa = hashed(a) + cz;
      ab = hashed(a + 1) + cz;
      ba = hashed(b) + cz;
      bb = hashed(b + 1) + cz;
      x1 = fx - 65536;
      y1 = fy - 65536;
      z1 = fz - 65536;
      near_z = blend(v,
        blend(u, slope(hashed(aa), fx, fy, fz), slope(hashed(ba), x1, fy, fz)),
        blend(u, slope(hashed(ab), fx, y1, fz), slope(hashed(bb), x1, y1, fz)));
      far_z = blend(v,
        blend(u, slope(hashed(aa + 1), fx, fy, z1), slope(hashed(ba + 1), x1, fy, z1)),
        blend(u, slope(hashed(ab + 1), fx, y1, z1), slope(hashed(bb + 1), x1, y1, z1)));
      return blend(w, near_z, far_z);
    endfunction

    function fgn_res_t fractal_sum(fgn_req_t r);
      fgn_res_t res;
      longint p[3];
      longint amp, total, ofs;
      int ch, n;
      ch = int'(r.channel);
      if (ch > int'(CH_TWO)) ch = int'(CH_NONE);
      n = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
      p[0] = longint'(r.pos_x);
      p[1] = longint'(r.pos_y);
      p[2] = longint'(r.pos_z);
      for (int k = 0; k < 3; k++) begin
        ofs = ((CH_OFFS[ch][k] << 16) + 5000) / 10000;
        p[k] = wrap40(p[k] + ofs);
      end
      amp = 65536;
      total = 0;
      for (int i = 0; i < n; i++) begin
        total += qmul(amp, lattice_noise(p[0], p[1], p[2]));
        amp = (amp * persist) >> 16;
        for (int k = 0; k < 3; k++) p[k] = wrap40((p[k] * lacun) >>> 12);
      end
      res.saturated = 1'b0;
      if (total > 2097151) begin
        total = 2097151;
        res.saturated = 1'b1;
      end else if (total < -2097152) begin
        total = -2097152;
        res.saturated = 1'b1;
      end
      res.noise_sum = total[21:0];
      return res;
    endfunction

    function void note_request(fgn_req_t r);
      pending.push_back(fractal_sum(r));
    endfunction

    function void check_result(fgn_res_t got);
      fgn_res_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result noise_sum=%0d saturated=%0b", $time,
                 got.noise_sum, got.saturated);
        return;
      end
      want = pending.pop_front();
      if (got.noise_sum !== want.noise_sum) begin
        errors++;
        $display("%0t: noise_sum expected %0d actual %0d", $time, want.noise_sum,
                 got.noise_sum);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fgn_req_t req;
  logic done;
  fgn_res_t result;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [15:0] cfg_data;

  noise_scoreboard sb;
  int idle_pct;
  int sent;
  int settings;

  fractal_gradient_noise_3d uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("fractal_gradient_noise_3d: mismatch");
    $finish;
  end

  // Mirror configuration writes and watch both handshakes.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_result(result);
    end
  end

  task automatic send_request(fgn_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int oct, int lac, int pers);
    write_reg(REG_OCTAVES, oct[15:0]);
    write_reg(REG_LACUN, lac[15:0]);
    write_reg(REG_PERSIST, pers[15:0]);
    settings++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
      2: return {16'($urandom_range(0, 65535)), 16'h0000}
                + 32'($urandom_range(0, 3)) - 32'd2;
      default: return {16'($urandom_range(0, 511) - 256), 16'($urandom)};
    endcase
  endfunction

  function automatic fgn_req_t rand_request();
    fgn_req_t r;
    r.pos_x = rand_coord();
    r.pos_y = rand_coord();
    r.pos_z = rand_coord();
    r.channel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    return r;
  endfunction

  function automatic fgn_req_t make_request(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [1:0] ch);
    fgn_req_t r;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.channel = ch;
    return r;
  endfunction

  initial begin
    sb = new();
    sent = 0;
    settings = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_OCTAVES;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, then a few directed points.
    send_request(make_request(32'h0, 32'h0, 32'h0, CH_NONE));
    send_request(make_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, CH_NONE));
    send_request(make_request(32'h80000000, 32'h80000000, 32'h80000000, CH_ONE));
    send_request(make_request(32'hffffffff, 32'h0000ffff, 32'hffff0001, CH_TWO));
    send_request(make_request(32'h00008000, 32'h00018000, 32'hfffe8000, 2'd3));
    send_request(make_request(32'h0000ffff, 32'h00000001, 32'h00010000, CH_ONE));
    drain();

    // Octave count above the maximum, with the largest lacunarity and persistence.
    configure(15, 65535, 65535);
    write_reg(REG_SPARE, 16'hffff);
    send_request(make_request(32'h00004000, 32'h0000c000, 32'h00002000, CH_NONE));
    send_request(make_request(32'hfff0c000, 32'h00304000, 32'h7fff8000, CH_TWO));
    send_request(make_request(32'h80000000, 32'h7fffffff, 32'h00000000, CH_ONE));
    drain();
    configure(0, 0, 0);
    send_request(make_request(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, CH_ONE));
    send_request(make_request(32'hffffffff, 32'hffffffff, 32'hffffffff, CH_TWO));
    drain();
    configure(8, 0, 65535);
    send_request(make_request(32'h00038000, 32'hfffc4000, 32'h00011111, CH_NONE));
    send_request(make_request(32'h7fffffff, 32'h80000000, 32'h00000000, 2'd3));
    drain();
    configure(1, 4096, 32768);
    send_request(make_request(32'h00004000, 32'h0000c000, 32'h00002000, CH_NONE));
    send_request(make_request(32'h00ff8000, 32'hff00ffff, 32'h00000001, CH_TWO));
    drain();

    // Random phases: the idle rate cycles through the prescribed mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 64;
        2: idle_pct = 0;
        default: idle_pct = 35;
      endcase
      case (ph)
        0: configure(8, 8192, 32768);
        1: configure(9, 65535, 65535);
        2: configure(2, 0, 0);
        default: configure($urandom_range(15), $urandom_range(65535),
                           $urandom_range(65535));
      endcase
      for (int i = 0; i < 220; i++) begin
        send_request(rand_request());
        // Once, in the fourth phase, hold off until the pipeline has emptied.
        if (i == 110 && ph == 3) begin
          start <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d requests over %0d register settings; %0d results checked.",
             sent, settings, sb.checked);
    if (sb.errors == 0) begin
      $display("fractal_gradient_noise_3d: match");
    end else begin
      $display("fractal_gradient_noise_3d: mismatch");
    end
    $finish;
  end
endmodule
